// ----- hdl/sighting_dedup_log_defines.svh -----
// ----------------------------------------------------------------------------
// sighting_dedup_log_defines.svh
// Assertion macros used by the sighting log RTL.
// ----------------------------------------------------------------------------
`ifndef SIGHTING_DEDUP_LOG_DEFINES_SVH
`define SIGHTING_DEDUP_LOG_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SDL_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sdl_pkg.sv -----
// ----------------------------------------------------------------------------
// sdl_pkg
// Types and constants of the sighting dedup log.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_APPENDED   = 3'd0,
        ST_REFRESHED  = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_RANGE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               func;
        logic [63:0]        name_low;
        logic [63:0]        name_high;
        logic [7:0]         name_length;
        logic               matched_flag;
        logic [7:0]         format_code;
        logic [47:0]        mac_address;
        logic signed [7:0]  signal_strength;
        logic [31:0]        now_seconds;
        logic [4:0]         read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         slot;
        logic [5:0]         entries_in_use;
        logic [63:0]        out_name_low;
        logic [63:0]        out_name_high;
        logic [4:0]         out_name_length;
        logic               out_matched;
        logic [7:0]         out_format;
        logic [47:0]        out_mac;
        logic signed [7:0]  out_strength;
        logic [15:0]        sightings;
        logic [31:0]        first_seen_seconds;
    } out_t;

    // normalized search key: name masked past its length, length clamped
    typedef struct packed {
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [4:0]  length;
        logic        matched;
        logic [7:0]  format;
        logic [47:0] mac;
        logic [7:0]  strength;
        logic [31:0] now;
    } key_t;

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  strength;
        logic [7:0]  format;
        logic        matched;
        logic [4:0]  length;
    } info_t;

    typedef struct packed {
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [47:0] mac;
        logic [31:0] first_seen;
        info_t       info;
    } entry_t;

    function automatic out_t make_out(status_t st, logic [4:0] slot, logic [5:0] used,
                                      entry_t e, logic with_entry);
        out_t o;
        o = '0;
        o.status         = st;
        o.slot           = slot;
        o.entries_in_use = used;
        if (with_entry) begin
            o.out_name_low       = e.name_low;
            o.out_name_high      = e.name_high;
            o.out_name_length    = e.info.length;
            o.out_matched        = e.info.matched;
            o.out_format         = e.info.format;
            o.out_mac            = e.mac;
            o.out_strength       = e.info.strength;
            o.sightings          = e.info.count;
            o.first_seen_seconds = e.first_seen;
        end
        return o;
    endfunction

endpackage

// ----- hdl/sdl_match.sv -----
// ----------------------------------------------------------------------------
// sdl_match
// Compares the search key with one stored entry and builds the refreshed
// entry for a hit and the fresh entry for an append.
// ----------------------------------------------------------------------------
module sdl_match (
    input  sdl_pkg::key_t   key,
    input  sdl_pkg::entry_t entry,
    output logic            hit,
    output sdl_pkg::entry_t refreshed,
    output sdl_pkg::entry_t fresh
);

    assign hit = (entry.info.length == key.length) &&
                 (entry.name_low == key.name_low) &&
                 (entry.name_high == key.name_high);

    always_comb begin
        refreshed               = entry;
        refreshed.info.strength = key.strength;
        if (entry.info.count != sdl_pkg::COUNT_MAX) begin
            refreshed.info.count = entry.info.count + 16'd1;
        end
        // a matched sighting upgrades the entry and its format
        if (key.matched) begin
            refreshed.info.matched = 1'b1;
            refreshed.info.format  = key.format;
        end
    end

    always_comb begin
        fresh.name_low      = key.name_low;
        fresh.name_high     = key.name_high;
        fresh.mac           = key.mac;
        fresh.first_seen    = key.now;
        fresh.info.count    = 16'd1;
        fresh.info.strength = key.strength;
        fresh.info.format   = key.format;
        fresh.info.matched  = key.matched;
        fresh.info.length   = key.length;
    end

endmodule

// ----- hdl/sighting_dedup_log.sv -----
// ----------------------------------------------------------------------------
// sighting_dedup_log
// Age-ordered log of distinct advertised names held in one entry memory.
// An add searches oldest first and refreshes or appends (an empty name is ignored);
// a read returns an entry by age position or reports the position out of range.
// ----------------------------------------------------------------------------
//  channel  | ports                      | request
//  ---------+----------------------------+---------------------------------
//  input    | s_valid, s_ready, s_data   | one add or read (sdl_pkg::in_t)
//  result   | m_valid, m_ready, m_data   | one result (sdl_pkg::out_t)
//
//  an add's search reads one memory entry per cycle through a single read port.
//  an empty name or a read out of range is answered without reading the memory.
//  reset clears the state, fill count, oldest pointer and valid flags only; the memory needs no pass.
//  a waiting result sits in the output register; the next request still runs,
//  then holds in S_DONE with s_ready low until the output register drains.
// ----------------------------------------------------------------------------
`include "sighting_dedup_log_defines.svh"

module sighting_dedup_log #(
    parameter int LOG_ENTRIES = 32,
    parameter int NAME_BYTES  = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sdl_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sdl_pkg::out_t  m_data
);

    localparam int IDX_W = $clog2(LOG_ENTRIES);
    localparam int AW    = IDX_W + 1;
    localparam int XW    = (AW > 5) ? AW : 5;

    sdl_pkg::state_t state_reg, state_next;
    sdl_pkg::key_t   key_reg, key_next, key_in;
    logic [AW-1:0]   age_reg, age_next;
    logic [AW-1:0]   cmp_age_reg, cmp_age_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]   count_reg, count_next;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    sdl_pkg::out_t   res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    sdl_pkg::out_t   m_data_reg, m_data_next;

    sdl_pkg::entry_t mem [LOG_ENTRIES];
    sdl_pkg::entry_t rd_data_reg;
    logic            mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    sdl_pkg::entry_t mem_wdata;

    logic            hit;
    sdl_pkg::entry_t refreshed, fresh;
    logic [4:0]      len_c;
    logic            ridx_ok;
    logic [AW-1:0]   ridx_age;
    logic            out_free;
    logic            full;

    // physical slot of an age position
    function automatic logic [IDX_W-1:0] phys(logic [IDX_W-1:0] base, logic [AW-1:0] age);
        logic [AW-1:0] sum;
        sum = {1'b0, base} + age;
        if (sum >= AW'(LOG_ENTRIES)) begin
            sum = sum - AW'(LOG_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    // key normalization: clamp length, zero bytes past it
    always_comb begin
        if (s_data.name_length > 8'(NAME_BYTES)) begin
            len_c = 5'(NAME_BYTES);
        end else begin
            len_c = s_data.name_length[4:0];
        end
        key_in.length   = len_c;
        key_in.matched  = s_data.matched_flag;
        key_in.format   = s_data.format_code;
        key_in.mac      = s_data.mac_address;
        key_in.strength = s_data.signal_strength;
        key_in.now      = s_data.now_seconds;
        for (int i = 0; i < 8; i++) begin
            key_in.name_low[i*8 +: 8]  = (5'(i) < len_c) ? s_data.name_low[i*8 +: 8] : 8'h00;
            key_in.name_high[i*8 +: 8] = (5'(i + 8) < len_c) ?
                                         s_data.name_high[i*8 +: 8] : 8'h00;
        end
    end

    assign ridx_ok  = XW'(s_data.read_index) < XW'(count_reg);
    assign ridx_age = AW'(s_data.read_index);
    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == AW'(LOG_ENTRIES));

    sdl_match u_match (
        .key       (key_reg),
        .entry     (rd_data_reg),
        .hit       (hit),
        .refreshed (refreshed),
        .fresh     (fresh)
    );

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        age_next     = age_reg;
        cmp_age_next = cmp_age_reg;
        cmp_vld_next = cmp_vld_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = fresh;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        case (state_reg)
            sdl_pkg::S_IDLE: begin
                if (s_valid) begin
                    key_next     = key_in;
                    age_next     = '0;
                    cmp_age_next = '0;
                    cmp_vld_next = 1'b0;
                    if (s_data.func == sdl_pkg::FUNC_READ) begin
                        if (ridx_ok) begin
                            mem_re     = 1'b1;
                            mem_raddr  = phys(oldest_reg, ridx_age);
                            age_next   = ridx_age;
                            state_next = sdl_pkg::S_READ;
                        end else begin
                            res_next   = sdl_pkg::make_out(sdl_pkg::ST_READ_RANGE,
                                             s_data.read_index, 6'(count_reg),
                                             sdl_pkg::entry_t'('0), 1'b0);
                            state_next = sdl_pkg::S_DONE;
                        end
                    end else if (s_data.name_length == 8'd0) begin
                        res_next   = sdl_pkg::make_out(sdl_pkg::ST_IGNORED, 5'd0,
                                         6'(count_reg), sdl_pkg::entry_t'('0), 1'b0);
                        state_next = sdl_pkg::S_DONE;
                    end else begin
                        state_next = sdl_pkg::S_SEARCH;
                    end
                end
            end
            sdl_pkg::S_READ: begin
                res_next   = sdl_pkg::make_out(sdl_pkg::ST_READ_OK, 5'(age_reg),
                                 6'(count_reg), rd_data_reg, 1'b1);
                state_next = sdl_pkg::S_DONE;
            end
            sdl_pkg::S_SEARCH: begin
                // compare the entry read last cycle; without a hit the next entry is read or the name appended
                if (cmp_vld_reg && hit) begin
                    mem_we     = 1'b1;
                    mem_waddr  = phys(oldest_reg, cmp_age_reg);
                    mem_wdata  = refreshed;
                    res_next   = sdl_pkg::make_out(sdl_pkg::ST_REFRESHED, 5'(cmp_age_reg),
                                     6'(count_reg), refreshed, 1'b1);
                    state_next = sdl_pkg::S_DONE;
                end else if (age_reg < count_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = phys(oldest_reg, age_reg);
                    cmp_vld_next = 1'b1;
                    cmp_age_next = age_reg;
                    age_next     = age_reg + 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = fresh;
                    if (full) begin
                        // overwrite the oldest slot, it becomes the newest
                        mem_waddr   = oldest_reg;
                        oldest_next = (oldest_reg == IDX_W'(LOG_ENTRIES - 1)) ?
                                      '0 : oldest_reg + 1'b1;
                        res_next    = sdl_pkg::make_out(sdl_pkg::ST_APPENDED,
                                          5'(LOG_ENTRIES - 1), 6'(count_reg), fresh, 1'b1);
                    end else begin
                        mem_waddr  = phys(oldest_reg, count_reg);
                        count_next = count_reg + 1'b1;
                        res_next   = sdl_pkg::make_out(sdl_pkg::ST_APPENDED, 5'(count_reg),
                                         6'(count_reg + 1'b1), fresh, 1'b1);
                    end
                    state_next = sdl_pkg::S_DONE;
                end
            end
            sdl_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = sdl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sdl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdl_pkg::S_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        age_reg     <= age_next;
        cmp_age_reg <= cmp_age_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign s_ready = (state_reg == sdl_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SDL_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= AW'(LOG_ENTRIES), "fill count above depth")
    `SDL_ASSERT_HOLDS(a_no_rw_clash, mem_we, !mem_re, "entry read and write in one cycle")
    `SDL_ASSERT_NEXT(a_write_finishes, mem_we, state_reg == sdl_pkg::S_DONE, "write not last step")
    `SDL_ASSERT_NEXT(a_result_loads, (state_reg == sdl_pkg::S_DONE) && out_free, m_valid_reg, "result lost")

endmodule

// ----- tb/sighting_log_checker.sv -----
// ----------------------------------------------------------------------------
// sighting_log_checker
// Watches both channels of the sighting log, keeps its own copy of the log
// and compares every result with the one predicted for the oldest request.
// ----------------------------------------------------------------------------
module sighting_log_checker
    import sdl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  in_t   s_data,
    input  logic  m_valid,
    input  logic  m_ready,
    input  out_t  m_data,
    output int    fail_count,
    output int    due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 32;
    localparam int NAME_MAX = 16;

    entry_t     log_mem [DEPTH];
    logic [4:0] oldest;
    int         used;
    out_t       due_results [$];
    out_t       want;

    initial begin
        fail_count = 0;
        due_count  = 0;
        oldest     = '0;
        used       = 0;
    end

    function automatic out_t entry_view(status_t st, int age, entry_t e);
        out_t o;
        o = '0;
        o.status             = st;
        o.slot               = 5'(age);
        o.entries_in_use     = 6'(used);
        o.out_name_low       = e.name_low;
        o.out_name_high      = e.name_high;
        o.out_name_length    = e.info.length;
        o.out_matched        = e.info.matched;
        o.out_format         = e.info.format;
        o.out_mac            = e.mac;
        o.out_strength       = e.info.strength;
        o.sightings          = e.info.count;
        o.first_seen_seconds = e.first_seen;
        return o;
    endfunction

    // updates the local log copy and returns the result the request should give
    function automatic out_t apply_sighting(in_t r);
        out_t       o;
        entry_t     e;
        logic [4:0] len;
        logic [4:0] p;
        logic [63:0] lo;
        logic [63:0] hi;
        bit         hit;
        int         a;
        o   = '0;
        e   = '0;
        lo  = '0;
        hi  = '0;
        hit = 0;
        a   = 0;
        p   = '0;
        if (r.func == FUNC_READ) begin
            if (r.read_index < used) begin
                p = oldest + r.read_index;
                o = entry_view(ST_READ_OK, r.read_index, log_mem[p]);
            end else begin
                o.status         = ST_READ_RANGE;
                o.slot           = r.read_index;
                o.entries_in_use = 6'(used);
            end
            return o;
        end
        if (r.name_length == 8'd0) begin
            o.status         = ST_IGNORED;
            o.entries_in_use = 6'(used);
            return o;
        end
        len = (r.name_length > NAME_MAX) ? 5'(NAME_MAX) : r.name_length[4:0];
        // bytes past the clamped length are dropped
        for (int b = 0; b < 8; b++) begin
            if (b < len) lo[8*b +: 8] = r.name_low[8*b +: 8];
            if (b + 8 < len) hi[8*b +: 8] = r.name_high[8*b +: 8];
        end
        // oldest first search
        while (!hit && a < used) begin
            p = oldest + 5'(a);
            if (log_mem[p].info.length == len && log_mem[p].name_low == lo &&
                log_mem[p].name_high == hi) begin
                hit = 1;
            end else begin
                a++;
            end
        end
        if (hit) begin
            e = log_mem[p];
            if (e.info.count != COUNT_MAX) e.info.count = e.info.count + 16'd1;
            if (r.matched_flag) begin
                e.info.matched = 1'b1;
                e.info.format  = r.format_code;
            end
            e.info.strength = r.signal_strength;
            log_mem[p] = e;
            return entry_view(ST_REFRESHED, a, e);
        end
        // full log drops its oldest entry
        if (used == DEPTH) oldest = oldest + 5'd1;
        else used++;
        a = used - 1;
        p = oldest + 5'(a);
        e.name_low      = lo;
        e.name_high     = hi;
        e.mac           = r.mac_address;
        e.first_seen    = r.now_seconds;
        e.info.count    = 16'd1;
        e.info.strength = r.signal_strength;
        e.info.format   = r.format_code;
        e.info.matched  = r.matched_flag;
        e.info.length   = len;
        log_mem[p] = e;
        return entry_view(ST_APPENDED, a, e);
    endfunction

    task automatic check_field(string field, logic [63:0] exp_val, logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            oldest = '0;
            used   = 0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: result with no request waiting, expected none actual %0h",
                             $time, m_data);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("slot", want.slot, m_data.slot);
                    check_field("entries_in_use", want.entries_in_use, m_data.entries_in_use);
                    check_field("out_name_low", want.out_name_low, m_data.out_name_low);
                    check_field("out_name_high", want.out_name_high, m_data.out_name_high);
                    check_field("out_name_length", want.out_name_length,
                                m_data.out_name_length);
                    check_field("out_matched", want.out_matched, m_data.out_matched);
                    check_field("out_format", want.out_format, m_data.out_format);
                    check_field("out_mac", want.out_mac, m_data.out_mac);
                    check_field("out_strength", want.out_strength, m_data.out_strength);
                    check_field("sightings", want.sightings, m_data.sightings);
                    check_field("first_seen_seconds", want.first_seen_seconds,
                                m_data.first_seen_seconds);
                end
            end
            if (s_valid && s_ready) due_results.push_back(apply_sighting(s_data));
        end
        due_count = due_results.size();
    end

endmodule

// ----- tb/tb_sighting_dedup_log.sv -----
// ----------------------------------------------------------------------------
// tb_sighting_dedup_log
// Drives adds and reads into the sighting log with random idling on both
// channels: a directed set of corner requests, then random traffic over a
// name pool larger than the log. The checker predicts and compares every
// result.
// ----------------------------------------------------------------------------
module tb_sighting_dedup_log;
    import sdl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 2000;
    localparam int POOL_SIZE    = 40;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [63:0] SEED_NAME = 64'h0000_0000_0074_6173;
    localparam logic [63:0] ONES      = '1;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    int    fail_count;
    int    due_count;
    int    cycle_count = 0;
    bit    quiet = 0;
    int    burst_left = 0;
    int    hold_asks = 0;
    int    holds_done = 0;

    logic [63:0] pool_lo  [POOL_SIZE];
    logic [63:0] pool_hi  [POOL_SIZE];
    logic [4:0]  pool_len [POOL_SIZE];

    always #5ns aclk = ~aclk;

    sighting_dedup_log u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sighting_log_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t noise_item();
        in_t r;
        r.func            = 1'($urandom);
        r.name_low        = {$urandom(), $urandom()};
        r.name_high       = {$urandom(), $urandom()};
        r.name_length     = 8'($urandom);
        r.matched_flag    = 1'($urandom);
        r.format_code     = 8'($urandom);
        r.mac_address     = {16'($urandom), $urandom()};
        r.signal_strength = 8'($urandom);
        r.now_seconds     = $urandom();
        r.read_index      = 5'($urandom);
        return r;
    endfunction

    function automatic in_t add_item(logic [63:0] lo, logic [63:0] hi, logic [7:0] len,
                                     logic m, logic [7:0] fmt, logic [47:0] mac,
                                     logic [7:0] str, logic [31:0] now);
        in_t r;
        r = noise_item();
        r.func            = FUNC_ADD;
        r.name_low        = lo;
        r.name_high       = hi;
        r.name_length     = len;
        r.matched_flag    = m;
        r.format_code     = fmt;
        r.mac_address     = mac;
        r.signal_strength = str;
        r.now_seconds     = now;
        return r;
    endfunction

    function automatic in_t read_item(logic [4:0] idx);
        in_t r;
        r = noise_item();
        r.func       = FUNC_READ;
        r.read_index = idx;
        return r;
    endfunction

    // pool name with fresh garbage above its length
    function automatic in_t pool_item(int k);
        in_t r;
        r = noise_item();
        r.func = FUNC_ADD;
        for (int b = 0; b < 8; b++) begin
            if (b < pool_len[k]) r.name_low[8*b +: 8] = pool_lo[k][8*b +: 8];
            if (b + 8 < pool_len[k]) r.name_high[8*b +: 8] = pool_hi[k][8*b +: 8];
        end
        r.name_length = 8'(pool_len[k]);
        if (pool_len[k] == 5'd16 && $urandom_range(0, 3) == 0)
            r.name_length = 8'($urandom_range(17, 255));
        r.matched_flag = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic offer(in_t r);
        int gap;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        gap = (quiet || burst_left > 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (due_count != 0);
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sighting_dedup_log test failed");
            $finish;
        end
    end

    // result side ready, with long holds on request
    initial begin
        int run;
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_asks != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end else begin
                run = $urandom_range(1, 20);
                gap = pick_gap();
                m_ready <= 1'b1;
                repeat (run) begin
                    @(negedge aclk);
                    if (hold_asks != holds_done) break;
                end
                if (gap > 0 && hold_asks == holds_done) begin
                    m_ready <= 1'b0;
                    repeat (gap) begin
                        @(negedge aclk);
                        if (hold_asks != holds_done) break;
                    end
                end
            end
        end
    end

    initial begin
        in_t r;
        int  pick;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = 5'($urandom_range(1, 16));
            pool_lo[i]  = {$urandom(), $urandom()};
            pool_hi[i]  = {$urandom(), $urandom()};
        end
        pool_len[0] = 5'd16;
        pool_len[1] = 5'd8;
        pool_len[2] = 5'd1;
        // same leading bytes, length one apart
        for (int i = 30; i < POOL_SIZE; i++) begin
            pool_lo[i]  = pool_lo[i - 30];
            pool_hi[i]  = pool_hi[i - 30];
            pool_len[i] = (pool_len[i - 30] == 5'd16) ? 5'd15 : pool_len[i - 30] + 5'd1;
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        offer(add_item(SEED_NAME, ONES, 8'd3, 1'b0, 8'd1, 48'h0000_0000_0001, 8'h80, 32'd7));
        offer(read_item(5'd0));
        offer(read_item(5'd1));
        offer(read_item(5'd31));
        offer(add_item(ONES, ONES, 8'd0, 1'b1, 8'hFF, '1, 8'h7F, '1));
        offer(add_item(ONES, ONES, 8'd255, 1'b0, 8'h00, '0, 8'h80, 32'd0));
        offer(add_item(ONES, ONES, 8'd16, 1'b1, 8'hFF, '1, 8'h7F, 32'hFFFF_FFFF));
        offer(add_item(ONES, ONES, 8'd17, 1'b0, 8'd1, 48'h1234_5678_9ABC, 8'd0, 32'd5));
        offer(add_item('0, '0, 8'd8, 1'b1, 8'd2, '1, 8'hC4, 32'd100));
        offer(add_item('0, ONES, 8'd8, 1'b0, 8'd1, '0, 8'h3B, 32'd101));
        offer(add_item('0, '0, 8'd9, 1'b0, 8'd1, '0, 8'hFF, 32'd102));
        offer(add_item(64'hA5A5_A5A5_A5A5_A541, ONES, 8'd1, 1'b0, 8'd1, '0, 8'h01, 32'd103));
        offer(add_item(64'h5A5A_5A5A_5A5A_5A41, '0, 8'd1, 1'b1, 8'd2, '1, 8'hFE, 32'd104));
        offer(add_item(64'h42, '0, 8'd1, 1'b1, 8'd2, '1, 8'h00, 32'd105));
        offer(read_item(5'd2));
        offer(read_item(5'd5));
        offer(read_item(5'd6));
        offer(read_item(5'd0));
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 400 == 200) quiet = 1;
            if (n % 400 == 300) quiet = 0;
            // result side stalls while requests keep coming
            if (n == 600 || n == 1500) begin
                hold_asks++;
                burst_left = 12;
            end
            if (n == 1200) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                r = pool_item($urandom_range(0, POOL_SIZE - 1));
            end else if (pick < 65) begin
                r = noise_item();
                r.func = FUNC_ADD;
                r.name_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 255))
                                                           : 8'($urandom_range(1, 16));
            end else if (pick < 70) begin
                r = noise_item();
                r.func = FUNC_ADD;
                r.name_length = 8'd0;
            end else begin
                r = read_item(5'($urandom_range(0, 31)));
            end
            offer(r);
            if (burst_left > 0) burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("sighting_dedup_log test passed");
        end else begin
            $display("sighting_dedup_log test failed");
        end
        $finish;
    end

endmodule

// ----- sighting_dedup_log.f -----
+incdir+hdl
hdl/sdl_pkg.sv
hdl/sdl_match.sv
hdl/sighting_dedup_log.sv
tb/sighting_log_checker.sv
tb/tb_sighting_dedup_log.sv
